// ===== sv/sbh_pkg.sv =====
// sbh_pkg: types and constants shared by the serial boot handshake host.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sbh_pkg;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_SENDING    = 4'd1,
        PH_VERIFYING  = 4'd2,
        PH_VERSION    = 4'd3,
        PH_CONNECTED  = 4'd4,
        PH_MISMATCH   = 4'd5,
        PH_BADVERSION = 4'd6,
        PH_AWAITCHECK = 4'd7,
        PH_LOADED     = 4'd8,
        PH_CHECKFAIL  = 4'd9
    } phase_t;

    typedef enum logic [2:0] {
        KIND_START       = 3'd0,
        KIND_TX_SLOT     = 3'd1,
        KIND_RX_BYTE     = 3'd2,
        KIND_SEND_WORD   = 3'd3,
        KIND_AWAIT_CHECK = 3'd4
    } kind_t;

    // One classified request handed from the front to the back.
    typedef struct packed {
        logic        word_cmd;   // expand word into eleven pulse-coded bytes
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic [3:0]  status;
        logic [7:0]  version;
        logic [31:0] word;
    } cmd_t;

    localparam logic [7:0] LFSR_SEED     = 8'h50;
    localparam logic [7:0] CAL_BYTE      = 8'hF9;
    localparam logic [7:0] BIT_BASE      = 8'hFE;
    localparam logic [7:0] PULSE_BASE    = 8'h92;
    localparam logic [7:0] PULSE_LAST    = 8'hF2;
    localparam logic [8:0] PRE_END       = 9'd251;
    localparam logic [8:0] HANDSHAKE_END = 9'd509;
    localparam logic [8:0] VERIFY_COUNT  = 9'd250;
    localparam logic [3:0] LAST_BEAT     = 4'd10;
    localparam logic [7:0] VERSION_RESET = 8'h01;

endpackage

`default_nettype wire

// ===== sv/serial_boot_handshake_host_top.sv =====
// A request is written into the command queue, then into the output register.
// While pop keeps the output register free: one request per cycle for single-result requests;
// a send-word request holds the result stage for its eleven encoded bytes, one byte a cycle.
// The command queue takes one further request while the back works through a word, then
// holds full until the closing byte of the word enters the output register.
// Reset: rst_n is asynchronous, active low; phase idle, LFSR 0x50, counters and version
// cleared, expected_version 1, queue and output register empty.
`timescale 1ns / 1ps
`default_nettype none

module serial_boot_handshake_host_top
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request side
    input  wire logic        push,
    output logic             full,
    input  wire logic [2:0]  kind,
    input  wire logic [7:0]  rx_byte,
    input  wire logic [31:0] word_data,
    // result side
    output logic             empty,
    input  wire logic        pop,
    output logic             tx_valid,
    output logic [7:0]       tx_byte,
    output logic             last,
    output logic [3:0]       status,
    output logic [7:0]       version,
    // expected version register
    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_data
);

    sbh_pkg::cmd_t front_cmd;
    sbh_pkg::cmd_t head_cmd;
    logic          accept;
    logic          head_valid;
    logic          head_pop;

    // Take a request only when the queue has room for its classified form.
    assign accept = push && !full;

    // Front: advance the protocol state and classify each request.
    sbh_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .kind      (kind),
        .rx_byte   (rx_byte),
        .word_data (word_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .cmd       (front_cmd)
    );

    // Hold classified requests so front and back can stall independently.
    sbh_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (accept),
        .wr_data  (front_cmd),
        .full     (full),
        .rd_en    (head_pop),
        .rd_valid (head_valid),
        .rd_data  (head_cmd)
    );

    // Back: drop each request into the output register, expanding words into eleven bytes.
    sbh_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head_cmd),
        .head_pop   (head_pop),
        .empty      (empty),
        .pop        (pop),
        .tx_valid   (tx_valid),
        .tx_byte    (tx_byte),
        .last       (last),
        .status     (status),
        .version    (version)
    );

endmodule

`default_nettype wire

// ===== sv/sbh_front.sv =====
// sbh_front: protocol state (LFSR, phase, counters) and request classification.
// Depends on sbh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbh_front
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic [2:0]    kind,
    input  wire logic [7:0]    rx_byte,
    input  wire logic [31:0]   word_data,
    input  wire logic          cfg_we,
    input  wire logic [7:0]    cfg_data,
    output sbh_pkg::cmd_t      cmd
);

    sbh_pkg::phase_t phase_reg, phase_next;
    logic [7:0] lfsr_reg, lfsr_next;
    logic [8:0] step_reg, step_next;
    logic [7:0] acc_reg, acc_next;
    logic [2:0] bidx_reg, bidx_next;
    logic [7:0] expected_reg;

    logic [7:0] lfsr_adv;
    logic       lfsr_bit;
    logic [7:0] rx_val;
    logic [7:0] rx_shifted;
    logic [8:0] step_inc;

    assign lfsr_bit   = lfsr_reg[0];
    assign lfsr_adv   = {lfsr_reg[6:0], lfsr_reg[7] ^ lfsr_reg[5] ^ lfsr_reg[4] ^ lfsr_reg[1]};
    assign rx_val     = rx_byte - sbh_pkg::BIT_BASE;
    assign rx_shifted = rx_val << bidx_reg;
    assign step_inc   = step_reg + 9'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= sbh_pkg::PH_IDLE;
            lfsr_reg     <= sbh_pkg::LFSR_SEED;
            step_reg     <= '0;
            acc_reg      <= '0;
            bidx_reg     <= '0;
            expected_reg <= sbh_pkg::VERSION_RESET;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                lfsr_reg  <= lfsr_next;
                step_reg  <= step_next;
                acc_reg   <= acc_next;
                bidx_reg  <= bidx_next;
            end
            if (cfg_we)
            begin
                expected_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        lfsr_next    = lfsr_reg;
        step_next    = step_reg;
        acc_next     = acc_reg;
        bidx_next    = bidx_reg;
        cmd.word_cmd = 1'b0;
        cmd.tx_valid = 1'b0;
        cmd.tx_byte  = '0;
        cmd.word     = word_data;

        unique case (sbh_pkg::kind_t'(kind))
            sbh_pkg::KIND_START:
            begin
                lfsr_next  = sbh_pkg::LFSR_SEED;
                phase_next = sbh_pkg::PH_SENDING;
                step_next  = '0;
                acc_next   = '0;
                bidx_next  = '0;
            end
            sbh_pkg::KIND_TX_SLOT:
            begin
                if (phase_reg == sbh_pkg::PH_SENDING)
                begin
                    cmd.tx_valid = 1'b1;
                    if (step_reg >= 9'd1 && step_reg < sbh_pkg::PRE_END)
                    begin
                        cmd.tx_byte = sbh_pkg::BIT_BASE | {7'd0, lfsr_bit};
                        lfsr_next   = lfsr_adv;
                    end
                    else
                    begin
                        cmd.tx_byte = sbh_pkg::CAL_BYTE;
                    end
                    if (step_inc >= sbh_pkg::HANDSHAKE_END)
                    begin
                        step_next  = '0;
                        phase_next = sbh_pkg::PH_VERIFYING;
                    end
                    else
                    begin
                        step_next = step_inc;
                    end
                end
                else if (phase_reg == sbh_pkg::PH_AWAITCHECK)
                begin
                    cmd.tx_valid = 1'b1;
                    cmd.tx_byte  = sbh_pkg::CAL_BYTE;
                end
            end
            sbh_pkg::KIND_RX_BYTE:
            begin
                if (phase_reg == sbh_pkg::PH_VERIFYING)
                begin
                    lfsr_next = lfsr_adv;
                    if (rx_val != {7'd0, lfsr_bit})
                    begin
                        phase_next = sbh_pkg::PH_MISMATCH;
                    end
                    else if (step_inc >= sbh_pkg::VERIFY_COUNT)
                    begin
                        step_next  = '0;
                        phase_next = sbh_pkg::PH_VERSION;
                        bidx_next  = '0;
                        acc_next   = '0;
                    end
                    else
                    begin
                        step_next = step_inc;
                    end
                end
                else if (phase_reg == sbh_pkg::PH_VERSION)
                begin
                    acc_next = acc_reg | rx_shifted;
                    if (bidx_reg == 3'd7)
                    begin
                        bidx_next  = '0;
                        phase_next = (acc_next == expected_reg) ? sbh_pkg::PH_CONNECTED
                                                                : sbh_pkg::PH_BADVERSION;
                    end
                    else
                    begin
                        bidx_next = bidx_reg + 3'd1;
                    end
                end
                else if (phase_reg == sbh_pkg::PH_AWAITCHECK)
                begin
                    phase_next = (rx_val != 8'd0) ? sbh_pkg::PH_CHECKFAIL
                                                  : sbh_pkg::PH_LOADED;
                end
            end
            sbh_pkg::KIND_SEND_WORD:
            begin
                cmd.word_cmd = 1'b1;
            end
            sbh_pkg::KIND_AWAIT_CHECK:
            begin
                if (phase_reg == sbh_pkg::PH_CONNECTED)
                begin
                    phase_next = sbh_pkg::PH_AWAITCHECK;
                end
            end
            default:
            begin
                cmd.tx_valid = 1'b0;
            end
        endcase

        cmd.status  = phase_next;
        cmd.version = acc_next;
    end

endmodule

`default_nettype wire

// ===== sv/sbh_cmd_queue.sv =====
// sbh_cmd_queue: short register FIFO of classified requests between front and back.
// Depends on sbh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbh_cmd_queue
#(
    parameter int DEPTH = 2
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire sbh_pkg::cmd_t wr_data,
    output logic               full,
    input  wire logic          rd_en,
    output logic               rd_valid,
    output sbh_pkg::cmd_t      rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    sbh_pkg::cmd_t    slot_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg, rptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_rd;

    assign full     = (count_reg == CNT_FULL);
    assign rd_valid = (count_reg != '0);
    assign rd_data  = slot_reg[rptr_reg];
    assign do_rd    = rd_en && rd_valid;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wptr_reg <= (wptr_reg == PTR_LAST) ? '0 : wptr_reg + PTR_W'(1);
            end
            if (do_rd)
            begin
                rptr_reg <= (rptr_reg == PTR_LAST) ? '0 : rptr_reg + PTR_W'(1);
            end
            if (wr_en && !do_rd)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_rd && !wr_en)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("command queue holds more than its depth");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && !do_rd) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("command queue count missed a write");
`endif

endmodule

`default_nettype wire

// ===== sv/sbh_back.sv =====
// sbh_back: expands queued requests into result items and holds the output register.
// Depends on sbh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbh_back
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          head_valid,
    input  wire sbh_pkg::cmd_t head,
    output logic               head_pop,
    output logic               empty,
    input  wire logic          pop,
    output logic               tx_valid,
    output logic [7:0]         tx_byte,
    output logic               last,
    output logic [3:0]         status,
    output logic [7:0]         version
);

    logic        out_valid_reg, out_valid_next;
    logic        tx_valid_reg, tx_valid_next;
    logic [7:0]  tx_byte_reg, tx_byte_next;
    logic        last_reg, last_next;
    logic [3:0]  status_reg, status_next;
    logic [7:0]  version_reg, version_next;
    logic [3:0]  beat_reg, beat_next;

    logic        advance;
    logic [5:0]  shamt;
    logic [31:0] word_sh;
    logic [7:0]  beat_byte;

    assign advance = !out_valid_reg || pop;
    assign shamt   = {1'b0, beat_reg, 1'b0} + {2'b00, beat_reg};
    assign word_sh = head.word >> shamt;

    always_comb
    begin
        if (beat_reg == sbh_pkg::LAST_BEAT)
        begin
            beat_byte = sbh_pkg::PULSE_LAST | {4'd0, word_sh[1], 2'd0, word_sh[0]};
        end
        else
        begin
            beat_byte = sbh_pkg::PULSE_BASE
                      | {1'b0, word_sh[2], 2'd0, word_sh[1], 2'd0, word_sh[0]};
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        tx_valid_next  = tx_valid_reg;
        tx_byte_next   = tx_byte_reg;
        last_next      = last_reg;
        status_next    = status_reg;
        version_next   = version_reg;
        beat_next      = beat_reg;
        head_pop       = 1'b0;

        if (advance)
        begin
            out_valid_next = head_valid;
            if (head_valid)
            begin
                status_next  = head.status;
                version_next = head.version;
                if (head.word_cmd)
                begin
                    tx_valid_next = 1'b1;
                    tx_byte_next  = beat_byte;
                    last_next     = (beat_reg == sbh_pkg::LAST_BEAT);
                    if (beat_reg == sbh_pkg::LAST_BEAT)
                    begin
                        beat_next = '0;
                        head_pop  = 1'b1;
                    end
                    else
                    begin
                        beat_next = beat_reg + 4'd1;
                    end
                end
                else
                begin
                    tx_valid_next = head.tx_valid;
                    tx_byte_next  = head.tx_byte;
                    last_next     = 1'b1;
                    head_pop      = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            beat_reg      <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            beat_reg      <= beat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tx_valid_reg <= tx_valid_next;
        tx_byte_reg  <= tx_byte_next;
        last_reg     <= last_next;
        status_reg   <= status_next;
        version_reg  <= version_next;
    end

    assign empty    = !out_valid_reg;
    assign tx_valid = tx_valid_reg;
    assign tx_byte  = tx_byte_reg;
    assign last     = last_reg;
    assign status   = status_reg;
    assign version  = version_reg;

`ifndef SYNTHESIS
    a_beat_on_word: assert property (@(posedge clk) disable iff (!rst_n)
        (beat_reg != 4'd0) |-> (head_valid && head.word_cmd))
        else $error("word expansion in progress without a word request at the head");

    a_beat_range: assert property (@(posedge clk) disable iff (!rst_n)
        beat_reg <= sbh_pkg::LAST_BEAT)
        else $error("word beat counter out of range");
`endif

endmodule

`default_nettype wire
